// File: rtl/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: shared types and helpers of the search table
// Entry layout, request and bound codes, sequencer states, quality function.
// ----------------------------------------------------------------------------
package sta_pkg;

   localparam int KEY_W   = 64;
   localparam int QUAL_W  = 12;

   typedef enum logic [1:0] {
      REQ_PROBE = 2'd0,
      REQ_STORE = 2'd1,
      REQ_AGE   = 2'd2,
      REQ_CLEAR = 2'd3
   } req_type;

   localparam logic [1:0] BOUND_NONE  = 2'd0;
   localparam logic [1:0] BOUND_EXACT = 2'd1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [15:0]      score;
      logic [7:0]       age;
      logic             mvalid;
      logic [15:0]      mv;
      logic [7:0]       depth;
      logic [7:0]       clock;
      logic [1:0]       bound;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_WRITE,
      ST_CLEAR
   } state_type;

   // Depth plus exact bonus minus four times the age distance
   function automatic logic signed [QUAL_W-1:0] quality(input entry_type e,
                                                        input logic [7:0] age);
      logic [7:0]        diff;
      logic [QUAL_W-1:0] sum;
      diff = age - e.age;
      sum  = {4'd0, e.depth} + {10'd0, (e.bound == BOUND_EXACT), 1'b0}
             - {2'd0, diff, 2'd0};
      return $signed(sum);
   endfunction

endpackage

// File: rtl/sta_ram.sv
// ----------------------------------------------------------------------------
// sta_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/search_table_age_depth_replace_core.sv
// ----------------------------------------------------------------------------
// search_table_age_depth_replace_core: set-associative game-search table
// Probe, store with depth/age replacement, new search and clear, one set
// row in RAM, ways scanned one per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   start / busy          req_type, req_key, req_move_present, ...
//  result    rsp_valid (1 cycle)   rsp_hit, rsp_written, rsp_score_out, ...
//
//  Probe/store: read, load, scan of k ways (1..WAYS), write-back; first a
//  set reduction (per 16-bit key digit, reciprocal multiply) when SETS
//  is not a power of two; one RAM row read and one row write-back per item.
//  New search: result next cycle.
//  Clear and reset: a clearing pass over all SETS rows, one row a cycle; busy.
//  The receiver cannot stall: each result shows for exactly one cycle.
module search_table_age_depth_replace_core #(
   parameter int SETS = 1024,
   parameter int WAYS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key,
   input  logic        req_move_present,
   input  logic [15:0] req_move_code,
   input  logic signed [15:0] req_score_in,
   input  logic [7:0]  req_depth_in,
   input  logic [7:0]  req_clock_in,
   input  logic [1:0]  req_bound_in,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_written,
   output logic signed [15:0] rsp_score_out,
   output logic        rsp_move_valid_out,
   output logic [15:0] rsp_move_out,
   output logic [7:0]  rsp_depth_out,
   output logic [7:0]  rsp_clock_out,
   output logic [1:0]  rsp_bound_out
);
   import sta_pkg::*;

   localparam int  IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int  WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int  ROW_W = $bits(entry_type) * WAYS;
   localparam bit  POW2  = (SETS & (SETS - 1)) == 0;
   localparam int  MOD_K = IDX_W + 17;
   localparam logic [17:0] MOD_R = 18'((64'd1 << MOD_K) / SETS);

   state_type state_ff, state_in;

   logic [1:0]       type_ff, type_in;
   logic [63:0]      key_ff, key_in;
   logic             mp_ff, mp_in;
   logic [15:0]      mcode_ff, mcode_in;
   logic [15:0]      score_ff, score_in;
   logic [7:0]       depth_ff, depth_in;
   logic [7:0]       clk_ff, clk_in;
   logic [1:0]       bound_ff, bound_in;
   logic [7:0]       age_ff, age_in;
   logic [IDX_W-1:0] set_ff, set_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clr_reply_ff, clr_reply_in;
   logic [IDX_W-1:0] mod_rem_ff, mod_rem_in;
   logic [63:0]      mod_sh_ff, mod_sh_in;
   logic [15:0]      mod_q_ff, mod_q_in;
   logic [2:0]       mod_cnt_ff, mod_cnt_in;
   entry_type [WAYS-1:0] row_ff, row_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic [WAY_W-1:0] vic_ff, vic_in;
   logic             found_ff, found_in;
   logic             qpick_ff, qpick_in;
   logic             hit_ff, hit_in;
   logic signed [QUAL_W-1:0] vq_ff, vq_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic        rsp_written_ff, rsp_written_in;
   entry_type   rsp_e_ff, rsp_e_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;
   logic [ROW_W-1:0] rd_data;

   sta_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SETS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(set_ff),
      .rd_data(rd_data)
   );

   // Hold state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      key_ff         <= key_in;
      mp_ff          <= mp_in;
      mcode_ff       <= mcode_in;
      score_ff       <= score_in;
      depth_ff       <= depth_in;
      clk_ff         <= clk_in;
      bound_ff       <= bound_in;
      set_ff         <= set_in;
      mod_rem_ff     <= mod_rem_in;
      mod_sh_ff      <= mod_sh_in;
      mod_q_ff       <= mod_q_in;
      mod_cnt_ff     <= mod_cnt_in;
      row_ff         <= row_in;
      way_ff         <= way_in;
      vic_ff         <= vic_in;
      found_ff       <= found_in;
      qpick_ff       <= qpick_in;
      hit_ff         <= hit_in;
      vq_ff          <= vq_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_written_ff <= rsp_written_in;
      rsp_e_ff       <= rsp_e_in;
   end

   // Sequencer: next state, scan step and RAM port
   always_comb begin
      entry_type                e;
      entry_type                new_e;
      entry_type [WAYS-1:0]     row_mod;
      logic                     ent_valid;
      logic                     key_eq;
      logic                     replace;
      logic                     stop;
      logic signed [QUAL_W-1:0] q;
      logic signed [QUAL_W-1:0] inc_q;
      logic [IDX_W+15:0]        mod_val;
      logic [IDX_W+33:0]        mod_prod;
      logic [IDX_W+15:0]        mod_diff;

      state_in       = state_ff;
      type_in        = type_ff;
      key_in         = key_ff;
      mp_in          = mp_ff;
      mcode_in       = mcode_ff;
      score_in       = score_ff;
      depth_in       = depth_ff;
      clk_in         = clk_ff;
      bound_in       = bound_ff;
      age_in         = age_ff;
      set_in         = set_ff;
      clr_cnt_in     = clr_cnt_ff;
      clr_reply_in   = clr_reply_ff;
      mod_rem_in     = mod_rem_ff;
      mod_sh_in      = mod_sh_ff;
      mod_q_in       = mod_q_ff;
      mod_cnt_in     = mod_cnt_ff;
      row_in         = row_ff;
      way_in         = way_ff;
      vic_in         = vic_ff;
      found_in       = found_ff;
      qpick_in       = qpick_ff;
      hit_in         = hit_ff;
      vq_in          = vq_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = 1'b0;
      rsp_written_in = 1'b0;
      rsp_e_in       = '0;
      wr_en          = 1'b0;
      wr_addr        = set_ff;
      wr_data        = row_ff;

      e         = row_ff[way_ff];
      ent_valid = e.bound != BOUND_NONE;
      key_eq    = e.key == key_ff;
      q         = quality(e, age_ff);
      inc_q     = $signed({4'd0, depth_ff} + {10'd0, (bound_ff == BOUND_EXACT), 1'b0});
      replace   = (e.clock != clk_ff) || (depth_ff >= e.depth) ||
                  ((bound_ff == BOUND_EXACT) && (({1'b0, depth_ff} + 9'd2) >= {1'b0, e.depth}));
      stop      = 1'b0;

      // Partial remainder with the next key digit appended
      mod_val   = {mod_rem_ff, mod_sh_ff[63:48]};
      mod_prod  = mod_val * MOD_R;
      mod_diff  = mod_val - ({{IDX_W{1'b0}}, mod_q_ff} * (IDX_W + 16)'(SETS));

      new_e        = '0;
      new_e.key    = key_ff;
      new_e.score  = score_ff;
      new_e.age    = age_ff;
      new_e.mvalid = mp_ff;
      new_e.mv     = mp_ff ? mcode_ff : 16'd0;
      new_e.depth  = depth_ff;
      new_e.clock  = clk_ff;
      new_e.bound  = bound_ff;
      row_mod      = row_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               type_in    = req_type;
               key_in     = req_key;
               mp_in      = req_move_present;
               mcode_in   = req_move_code;
               score_in   = req_score_in;
               depth_in   = req_depth_in;
               clk_in     = req_clock_in;
               bound_in   = req_bound_in;
               set_in     = req_key[IDX_W-1:0] & IDX_W'(SETS - 1);
               mod_rem_in = '0;
               mod_sh_in  = req_key;
               mod_cnt_in = '0;
               case (req_type)
                  REQ_PROBE, REQ_STORE: begin
                     state_in = POW2 ? ST_READ : ST_MOD;
                  end
                  REQ_AGE: begin
                     age_in       = age_ff + 8'd1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     age_in       = '0;
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_MOD: begin
            // Reduce the key one 16-bit digit at a time, most significant first
            if (!mod_cnt_ff[0]) begin
               // Estimate the quotient digit from the reciprocal
               mod_q_in = mod_prod[MOD_K +: 16];
            end else begin
               // Take the remainder; the estimate is at most one short
               if (mod_diff >= (IDX_W + 16)'(SETS)) begin
                  mod_rem_in = mod_diff[IDX_W-1:0] - IDX_W'(SETS);
               end else begin
                  mod_rem_in = mod_diff[IDX_W-1:0];
               end
               mod_sh_in = {mod_sh_ff[47:0], 16'd0};
               if (mod_cnt_ff == 3'd7) begin
                  set_in   = mod_rem_in;
                  state_in = ST_READ;
               end
            end
            mod_cnt_in = mod_cnt_ff + 3'd1;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            row_in   = rd_data;
            way_in   = '0;
            found_in = 1'b0;
            qpick_in = 1'b0;
            hit_in   = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Examine one way per cycle
            if (type_ff == REQ_PROBE) begin
               if (ent_valid && key_eq) begin
                  row_in[way_ff].age = age_ff;
                  hit_in             = 1'b1;
                  vic_in             = way_ff;
                  stop               = 1'b1;
               end
            end else if (!ent_valid) begin
               vic_in   = way_ff;
               found_in = 1'b1;
               qpick_in = 1'b0;
               stop     = 1'b1;
            end else if (key_eq) begin
               if (replace) begin
                  vic_in   = way_ff;
                  found_in = 1'b1;
                  qpick_in = 1'b0;
               end else begin
                  // Keep the deeper entry: refresh age, take the move
                  row_in[way_ff].age = age_ff;
                  if (mp_ff) begin
                     row_in[way_ff].mvalid = 1'b1;
                     row_in[way_ff].mv     = mcode_ff;
                  end
               end
               stop = 1'b1;
            end else if (!found_ff || (q < vq_ff)) begin
               vic_in   = way_ff;
               vq_in    = q;
               found_in = 1'b1;
               qpick_in = 1'b1;
            end
            if (stop || (way_ff == WAY_W'(WAYS - 1))) begin
               state_in = ST_WRITE;
            end else begin
               way_in = way_ff + WAY_W'(1);
            end
         end
         ST_WRITE: begin
            // Write the row back and issue the result
            wr_en        = 1'b1;
            rsp_valid_in = 1'b1;
            if (type_ff == REQ_STORE) begin
               if (found_ff && !(qpick_ff && (inc_q < vq_ff))) begin
                  row_mod[vic_ff] = new_e;
                  rsp_written_in  = 1'b1;
               end
            end else if (hit_ff) begin
               rsp_hit_in = 1'b1;
               rsp_e_in   = row_ff[vic_ff];
            end
            wr_data  = row_mod;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            // Sweep every row to empty
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(SETS - 1)) begin
               rsp_valid_in = clr_reply_ff;
               clr_reply_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_written        = rsp_written_ff;
   assign rsp_score_out      = $signed(rsp_e_ff.score);
   assign rsp_move_valid_out = rsp_e_ff.mvalid;
   assign rsp_move_out       = rsp_e_ff.mv;
   assign rsp_depth_out      = rsp_e_ff.depth;
   assign rsp_clock_out      = rsp_e_ff.clock;
   assign rsp_bound_out      = rsp_e_ff.bound;

   // A hit is never reported together with a write
   a_hit_not_written: assert property (@(posedge clock) disable iff (reset)
      rsp_hit |-> !rsp_written)
      else $error("hit and written together");

   // Result fields are zero without a strobe
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (!rsp_hit && !rsp_written && rsp_depth_out == 8'd0))
      else $error("result fields set without strobe");

   // A probe or store keeps the block busy in the next cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_PROBE || req_type == REQ_STORE)) |=> busy)
      else $error("lookup did not raise busy");

   // The clearing pass holds off requests
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("idle during clear");

endmodule
